@@ hw/rtl/isfe_pkg.sv @@
// shared types and constants for the inverse-square field evaluator
package isfe_pkg;

  localparam int MAX_BODIES_DEF = 8;
  localparam int COORD_W        = 24;
  localparam int MASS_W         = 32;
  localparam int FIELD_W        = 40;
  localparam int ACTIVE_W       = 4;
  localparam int DIFF_W         = COORD_W + 1;
  localparam int MAG_W          = COORD_W;
  localparam int D2_W           = 50;
  localparam int RAD_W          = 64;
  localparam int ROOT_W         = 32;
  localparam int DEN_W          = 82;
  localparam int PROD_W         = 64;
  localparam int NUM_W          = 97;
  localparam int NUM_SHIFT      = 41;
  localparam int Q_W            = 40;
  localparam logic [D2_W-1:0] SKIP_D2 = D2_W'(43);

  localparam logic opcode_load = 1'b0;
  localparam logic opcode_eval = 1'b1;

  typedef struct packed {
    logic [MASS_W-1:0]         mass;
    logic signed [COORD_W-1:0] z;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } body_t;

endpackage

@@ hw/rtl/isfe_body_mem.sv @@
// body table memory with per-entry valid bits, registered read
module isfe_body_mem #(
  parameter int MAX_BODIES = isfe_pkg::MAX_BODIES_DEF,
  localparam int IDX_W = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    wr_en,
  input  logic [IDX_W-1:0]        wr_addr,
  input  isfe_pkg::body_t         wr_data,
  input  logic                    rd_en,
  input  logic [IDX_W-1:0]        rd_addr,
  output isfe_pkg::body_t         rd_data
);
  isfe_pkg::body_t       mem [MAX_BODIES];
  logic [MAX_BODIES-1:0] valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  // entries never loaded read as the cleared value
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= valid[rd_addr] ? mem[rd_addr] : '0;
    end
  end

endmodule

@@ hw/rtl/isfe_sqrt.sv @@
// iterative integer square root, two radicand bits per cycle
module isfe_sqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [isfe_pkg::RAD_W-1:0]    radicand,
  output logic                          done,
  output logic [isfe_pkg::ROOT_W-1:0]   root
);
  localparam int STEPS = isfe_pkg::RAD_W / 2;

  logic [isfe_pkg::RAD_W-1:0] v;
  logic [isfe_pkg::RAD_W-1:0] res;
  logic [isfe_pkg::RAD_W-1:0] bitv;
  logic [$clog2(STEPS)-1:0]   cnt;
  logic                       busy;
  logic [isfe_pkg::RAD_W-1:0] trial;

  assign trial = res + bitv;
  assign root  = res[isfe_pkg::ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        v    <= radicand;
        res  <= '0;
        bitv <= {2'b01, {(isfe_pkg::RAD_W-2){1'b0}}};
      end else if (busy) begin
        if (v >= trial) begin
          v   <= v - trial;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
        cnt  <= cnt + 1'b1;
        if (cnt == $clog2(STEPS)'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ hw/rtl/isfe_div.sv @@
// restoring divider, one quotient bit per cycle, keeps 40 quotient bits plus overflow
module isfe_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [isfe_pkg::NUM_W-1:0]  num,
  input  logic [isfe_pkg::DEN_W-1:0]  den,
  output logic                        done,
  output logic [isfe_pkg::Q_W-1:0]    quot,
  output logic                        ovf
);
  localparam int CNT_W = $clog2(isfe_pkg::NUM_W);

  logic [isfe_pkg::NUM_W-1:0] n;
  logic [isfe_pkg::DEN_W-1:0] d;
  logic [isfe_pkg::DEN_W-1:0] rem;
  logic [CNT_W-1:0]           cnt;
  logic                       busy;
  logic [isfe_pkg::DEN_W:0]   sh;
  logic                       ge;

  assign sh = {rem, n[isfe_pkg::NUM_W-1]};
  assign ge = sh >= {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        n    <= num;
        d    <= den;
        rem  <= '0;
        quot <= '0;
        ovf  <= 1'b0;
      end else if (busy) begin
        n    <= n << 1;
        rem  <= ge ? isfe_pkg::DEN_W'(sh - {1'b0, d}) : sh[isfe_pkg::DEN_W-1:0];
        quot <= {quot[isfe_pkg::Q_W-2:0], ge};
        // a bit leaving the top means the quotient is past the field range
        ovf  <= ovf | quot[isfe_pkg::Q_W-1];
        cnt  <= cnt + 1'b1;
        if (cnt == CNT_W'(isfe_pkg::NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ hw/rtl/inverse_square_field_eval.sv @@
// Inverse-square field evaluator: body table in memory, per-body sequencer.
// Input items arrive on s_axis. tuser is the opcode: 0 loads a body into the
// table slot, 1 evaluates the summed field at the given point. A load is
// written in the cycle it is accepted and makes no output item. An evaluate
// item makes one output item on m_axis: three saturating Q6.34 components
// in tdata and the clip flag in tuser.
// An evaluation walks the first min(active_bodies, MAX_BODIES) table entries.
// Each body reads its entry, takes the differences, forms the distance square
// through a shared 32x32 multiplier, checks the skip distance, takes a 32-step
// square root, forms the 82-bit denominator and runs three 97-step divisions,
// one per axis, then steps to the next body; a skipped body goes from the skip
// check straight to that step. The output item is loaded in ST_DONE after the
// last body's ST_NEXT, and waits there while the output register is still full.
// s_axis_tready is high only while the sequencer is idle. The result waits in
// an output register; a new item is accepted while it waits, and a finished
// evaluation holds until the receiver takes the earlier one. Reset clears the
// table, active_bodies and all handshake state at once. The user must write
// active_bodies via cfg_we/cfg_wdata only while idle; the block does not check.
module inverse_square_field_eval #(
  parameter int MAX_BODIES = isfe_pkg::MAX_BODIES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [3:0]    cfg_wdata,       // active_bodies
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [111:0]  s_axis_tdata,    // body_slot[2:0], coord_x, coord_y, coord_z, mass_in
  input  logic          s_axis_tuser,    // opcode
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [119:0]  m_axis_tdata,    // field_x, field_y, field_z
  output logic          m_axis_tuser     // saturated
);
  localparam int IDX_W = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;
  localparam int CNT_W = $clog2(MAX_BODIES + 1);
  localparam int FW    = isfe_pkg::FIELD_W;
  localparam logic signed [FW:0] FMAX = {2'b00, {(FW-1){1'b1}}};
  localparam logic signed [FW:0] FMIN = {2'b11, {(FW-1){1'b0}}};

  typedef enum logic [4:0] {
    ST_IDLE, ST_RD, ST_DIFF, ST_SQ0, ST_SQ1, ST_SQ2, ST_SQ3, ST_CHK, ST_ROOT,
    ST_DEN0, ST_DEN1, ST_DEN2, ST_AXMUL, ST_AXGO, ST_AXDIV, ST_AXADD, ST_NEXT,
    ST_DONE
  } state_t;

  state_t state;

  logic [isfe_pkg::ACTIVE_W-1:0]       active_bodies;
  logic                                in_acc;
  logic [2:0]                          body_slot;
  isfe_pkg::body_t                     in_body;
  logic                                wr_en;
  isfe_pkg::body_t                     rd_data;
  logic [CNT_W-1:0]                    count;
  logic [CNT_W-1:0]                    k;
  logic [CNT_W-1:0]                    count_next;
  logic signed [isfe_pkg::COORD_W-1:0] px, py, pz;
  logic [isfe_pkg::MASS_W-1:0]         mass;
  logic [isfe_pkg::MAG_W-1:0]          mag [3];
  logic [2:0]                          neg;
  logic signed [isfe_pkg::DIFF_W-1:0]  dx, dy, dz;
  logic [isfe_pkg::D2_W-1:0]           d2;
  logic [isfe_pkg::DEN_W-1:0]          den;
  logic [isfe_pkg::PROD_W-1:0]         prod;
  logic [31:0]                         mul_a, mul_b;
  logic [isfe_pkg::PROD_W-1:0]         mul_p;
  logic [1:0]                          ax;
  logic signed [FW-1:0]                acc [3];
  logic                                sat;
  logic                                sqrt_start, sqrt_done;
  logic [isfe_pkg::ROOT_W-1:0]         root;
  logic                                div_start, div_done, div_ovf;
  logic [isfe_pkg::Q_W-1:0]            quot;
  logic                                clip;
  logic [FW-1:0]                       tmag;
  logic signed [FW:0]                  term, sum;

  assign s_axis_tready = (state == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign body_slot     = s_axis_tdata[2:0];
  assign in_body.x     = s_axis_tdata[26:3];
  assign in_body.y     = s_axis_tdata[50:27];
  assign in_body.z     = s_axis_tdata[74:51];
  assign in_body.mass  = s_axis_tdata[106:75];
  assign wr_en = in_acc && (s_axis_tuser == isfe_pkg::opcode_load) &&
                 (32'(body_slot) < MAX_BODIES);

  assign count_next = (32'(active_bodies) > MAX_BODIES) ? CNT_W'(MAX_BODIES)
                                                        : CNT_W'(active_bodies);

  isfe_body_mem #(.MAX_BODIES(MAX_BODIES)) u_mem (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (IDX_W'(body_slot)),
    .wr_data (in_body),
    .rd_en   (state == ST_RD),
    .rd_addr (k[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  assign sqrt_start = (state == ST_CHK) && (d2 >= isfe_pkg::SKIP_D2);

  isfe_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand ({d2, 14'b0}),
    .done     (sqrt_done),
    .root     (root)
  );

  assign div_start = (state == ST_AXGO);

  isfe_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   ({prod[isfe_pkg::NUM_W-isfe_pkg::NUM_SHIFT-1:0], {isfe_pkg::NUM_SHIFT{1'b0}}}),
    .den   (den),
    .done  (div_done),
    .quot  (quot),
    .ovf   (div_ovf)
  );

  assign dx = isfe_pkg::DIFF_W'(px) - isfe_pkg::DIFF_W'(rd_data.x);
  assign dy = isfe_pkg::DIFF_W'(py) - isfe_pkg::DIFF_W'(rd_data.y);
  assign dz = isfe_pkg::DIFF_W'(pz) - isfe_pkg::DIFF_W'(rd_data.z);

  // one shared multiplier, its product always registered
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_SQ0:   begin mul_a = 32'(mag[0]); mul_b = 32'(mag[0]); end
      ST_SQ1:   begin mul_a = 32'(mag[1]); mul_b = 32'(mag[1]); end
      ST_SQ2:   begin mul_a = 32'(mag[2]); mul_b = 32'(mag[2]); end
      ST_DEN0:  begin mul_a = d2[31:0]; mul_b = root; end
      ST_DEN1:  begin mul_a = 32'(d2[isfe_pkg::D2_W-1:32]); mul_b = root; end
      ST_AXMUL: begin mul_a = 32'(mag[ax]); mul_b = mass; end
      default:  begin mul_a = '0; mul_b = '0; end
    endcase
  end
  assign mul_p = 64'(mul_a) * 64'(mul_b);

  assign clip = div_ovf | quot[isfe_pkg::Q_W-1];
  assign tmag = clip ? FW'(FMAX) : quot;
  assign term = neg[ax] ? -$signed({1'b0, tmag}) : $signed({1'b0, tmag});
  assign sum  = $signed({acc[ax][FW-1], acc[ax]}) + term;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      active_bodies <= '0;
      m_axis_tvalid <= 1'b0;
      k             <= '0;
      count         <= '0;
      ax            <= '0;
      sat           <= 1'b0;
    end else begin
      if (cfg_we) begin
        active_bodies <= cfg_wdata;
      end
      if (m_axis_tvalid && m_axis_tready && state != ST_DONE) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_acc && s_axis_tuser == isfe_pkg::opcode_eval) begin
            px     <= in_body.x;
            py     <= in_body.y;
            pz     <= in_body.z;
            count  <= count_next;
            k      <= '0;
            sat    <= 1'b0;
            acc[0] <= '0;
            acc[1] <= '0;
            acc[2] <= '0;
            state  <= (count_next == '0) ? ST_DONE : ST_RD;
          end
        end
        ST_RD: state <= ST_DIFF;
        ST_DIFF: begin
          mag[0] <= isfe_pkg::MAG_W'(dx[isfe_pkg::DIFF_W-1] ? -dx : dx);
          mag[1] <= isfe_pkg::MAG_W'(dy[isfe_pkg::DIFF_W-1] ? -dy : dy);
          mag[2] <= isfe_pkg::MAG_W'(dz[isfe_pkg::DIFF_W-1] ? -dz : dz);
          neg    <= {dz[isfe_pkg::DIFF_W-1], dy[isfe_pkg::DIFF_W-1], dx[isfe_pkg::DIFF_W-1]};
          mass   <= rd_data.mass;
          state  <= ST_SQ0;
        end
        ST_SQ0: begin
          prod  <= mul_p;
          state <= ST_SQ1;
        end
        ST_SQ1: begin
          d2    <= isfe_pkg::D2_W'(prod);
          prod  <= mul_p;
          state <= ST_SQ2;
        end
        ST_SQ2: begin
          d2    <= d2 + isfe_pkg::D2_W'(prod);
          prod  <= mul_p;
          state <= ST_SQ3;
        end
        ST_SQ3: begin
          d2    <= d2 + isfe_pkg::D2_W'(prod);
          state <= ST_CHK;
        end
        // bodies too close to the point are skipped
        ST_CHK: state <= (d2 >= isfe_pkg::SKIP_D2) ? ST_ROOT : ST_NEXT;
        ST_ROOT: begin
          if (sqrt_done) begin
            state <= ST_DEN0;
          end
        end
        ST_DEN0: begin
          prod  <= mul_p;
          state <= ST_DEN1;
        end
        ST_DEN1: begin
          den   <= isfe_pkg::DEN_W'(prod);
          prod  <= mul_p;
          state <= ST_DEN2;
        end
        ST_DEN2: begin
          den   <= den + {prod[isfe_pkg::DEN_W-33:0], 32'b0};
          ax    <= '0;
          state <= ST_AXMUL;
        end
        ST_AXMUL: begin
          prod  <= mul_p;
          state <= ST_AXGO;
        end
        ST_AXGO: state <= ST_AXDIV;
        ST_AXDIV: begin
          if (div_done) begin
            state <= ST_AXADD;
          end
        end
        ST_AXADD: begin
          if (clip) begin
            sat <= 1'b1;
          end
          if (sum > FMAX) begin
            acc[ax] <= FW'(FMAX);
            sat     <= 1'b1;
          end else if (sum < FMIN) begin
            acc[ax] <= FW'(FMIN);
            sat     <= 1'b1;
          end else begin
            acc[ax] <= FW'(sum);
          end
          if (ax == 2'd2) begin
            state <= ST_NEXT;
          end else begin
            ax    <= ax + 1'b1;
            state <= ST_AXMUL;
          end
        end
        ST_NEXT: begin
          k     <= k + 1'b1;
          state <= (k + 1'b1 == count) ? ST_DONE : ST_RD;
        end
        ST_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {acc[2], acc[1], acc[0]};
            m_axis_tuser  <= sat;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ sim/isfe_checker.sv @@
// field checker: tracks the body table, predicts each field result and compares
module isfe_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [3:0]   cfg_wdata,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [111:0] s_axis_tdata,
  input  logic         s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [119:0] m_axis_tdata,
  input  logic         m_axis_tuser,
  output int           errors,
  output int           fields_waiting,
  output int           fields_seen
);
  localparam int NBODY = isfe_pkg::MAX_BODIES_DEF;
  localparam int FW    = isfe_pkg::FIELD_W;
  localparam longint FMAX = 64'sd549755813887;
  localparam longint FMIN = -FMAX - 1;

  typedef struct {
    logic signed [FW-1:0] fx;
    logic signed [FW-1:0] fy;
    logic signed [FW-1:0] fz;
    logic                 sat;
  } field_t;

  isfe_pkg::body_t table_q [NBODY];
  logic [3:0]      active_cnt;
  field_t          field_q [$];

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // one axis of one body: sign(d) * floor(floor(|d| * m * 2^41 / d2) / r), clipped
  function automatic longint axis_term(input longint dc, input logic [31:0] m,
                                       input logic [63:0] d2, input logic [63:0] r,
                                       inout logic sat);
    logic [127:0] num;
    logic [127:0] q;
    logic [63:0]  mag;
    longint       t;
    mag = (dc < 0) ? -dc : dc;
    num = 128'(mag) * 128'(m);
    num = num << isfe_pkg::NUM_SHIFT;
    q = (num / 128'(d2)) / 128'(r);
    if (q > 128'(FMAX)) begin
      sat = 1'b1;
      t = FMAX;
    end else begin
      t = longint'(q[63:0]);
    end
    return (dc < 0) ? -t : t;
  endfunction

  function automatic longint clip_sum(input longint v, inout logic sat);
    if (v > FMAX) begin
      sat = 1'b1;
      return FMAX;
    end
    if (v < FMIN) begin
      sat = 1'b1;
      return FMIN;
    end
    return v;
  endfunction

  function automatic field_t sum_field(input logic signed [23:0] px,
                                       input logic signed [23:0] py,
                                       input logic signed [23:0] pz);
    field_t      res;
    int          n;
    longint      dc [3];
    longint      acc [3];
    longint      t;
    logic [63:0] d2;
    logic [63:0] r;
    logic        sat;
    sat = 1'b0;
    acc[0] = 0; acc[1] = 0; acc[2] = 0;
    n = (active_cnt > NBODY) ? NBODY : active_cnt;
    for (int k = 0; k < n; k++) begin
      dc[0] = longint'(px) - longint'(table_q[k].x);
      dc[1] = longint'(py) - longint'(table_q[k].y);
      dc[2] = longint'(pz) - longint'(table_q[k].z);
      d2 = dc[0] * dc[0] + dc[1] * dc[1] + dc[2] * dc[2];
      if (d2 < 64'(isfe_pkg::SKIP_D2)) continue;
      r = int_sqrt(d2 << 14);
      for (int a = 0; a < 3; a++) begin
        t = axis_term(dc[a], table_q[k].mass, d2, r, sat);
        acc[a] = clip_sum(acc[a] + t, sat);
      end
    end
    res.fx = acc[0][FW-1:0];
    res.fy = acc[1][FW-1:0];
    res.fz = acc[2][FW-1:0];
    res.sat = sat;
    return res;
  endfunction

  task automatic report(input string what, input logic [FW-1:0] want,
                        input logic [FW-1:0] got);
    $display("field result %0d: %s expected %h got %h", fields_seen, what, want, got);
    errors++;
  endtask

  always @(posedge clk) begin
    field_t want;
    if (rst) begin
      for (int k = 0; k < NBODY; k++) table_q[k] <= '0;
      active_cnt <= '0;
      field_q.delete();
      fields_waiting <= 0;
    end else begin
      if (cfg_we) active_cnt <= cfg_wdata;
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == isfe_pkg::opcode_load) begin
          table_q[s_axis_tdata[2:0]] <= {s_axis_tdata[106:75], s_axis_tdata[74:51],
                                         s_axis_tdata[50:27], s_axis_tdata[26:3]};
        end else begin
          field_q.insert(field_q.size(), sum_field(s_axis_tdata[26:3], s_axis_tdata[50:27],
                                                   s_axis_tdata[74:51]));
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (field_q.size() == 0) begin
          $display("field result with nothing outstanding: %h", m_axis_tdata);
          errors++;
        end else begin
          want = field_q.pop_front();
          if (m_axis_tdata[39:0] !== want.fx) report("field_x", want.fx, m_axis_tdata[39:0]);
          if (m_axis_tdata[79:40] !== want.fy) report("field_y", want.fy, m_axis_tdata[79:40]);
          if (m_axis_tdata[119:80] !== want.fz)
            report("field_z", want.fz, m_axis_tdata[119:80]);
          if (m_axis_tuser !== want.sat) report("saturated", 40'(want.sat), 40'(m_axis_tuser));
        end
        fields_seen++;
      end
      fields_waiting <= field_q.size();
    end
  end

  initial begin
    errors = 0;
    fields_seen = 0;
    fields_waiting = 0;
  end
endmodule

@@ sim/tb_top.sv @@
// top of the field evaluator bench: clock, reset, stimulus and verdict
module tb_top;
  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_we = 1'b0;
  logic [3:0]   cfg_wdata = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [111:0] s_axis_tdata = '0;   // body_slot, coord_x, coord_y, coord_z, mass_in, zero pad
  logic         s_axis_tuser = 1'b0; // opcode
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [119:0] m_axis_tdata;        // field_x, field_y, field_z
  logic         m_axis_tuser;        // saturated
  int           errors;
  int           fields_waiting;
  int           fields_seen;
  int           send_idle = 0;
  int           recv_stall = 0;
  int           loads_sent = 0;
  int           evals_sent = 0;
  logic signed [23:0] body_x [8];
  logic signed [23:0] body_y [8];
  logic signed [23:0] body_z [8];
  logic [3:0]   counts [12] = '{1, 2, 0, 3, 1, 8, 2, 15, 1, 4, 2, 9};

  inverse_square_field_eval uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  isfe_checker chk (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .errors(errors), .fields_waiting(fields_waiting), .fields_seen(fields_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(99) >= recv_stall);
  end

  // called just after a rising edge, returns just after the edge that took the item
  task automatic send(input logic op, input logic [2:0] slot, input logic signed [23:0] x,
                      input logic signed [23:0] y, input logic signed [23:0] z,
                      input logic [31:0] mass);
    if ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {5'b0, mass, z, y, x, slot};
    do @(negedge clk); while (!s_axis_tready);
    @(posedge clk);
    if (op == isfe_pkg::opcode_load) begin
      loads_sent++;
      body_x[slot] = x; body_y[slot] = y; body_z[slot] = z;
    end else begin
      evals_sent++;
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (fields_waiting != 0);
    @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_active(input logic [3:0] n);
    cfg_we <= 1'b1;
    cfg_wdata <= n;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [23:0] pick_coord();
    case ($urandom_range(3))
      0: return 24'($urandom);
      1: return 24'($urandom_range(131071)) - 24'sd65536;
      2: return $urandom_range(1) ? 24'sh7fffff : 24'sh800000;
      default: return 24'($urandom_range(255)) - 24'sd128;
    endcase
  endfunction

  function automatic logic [31:0] pick_mass();
    case ($urandom_range(2))
      0: return $urandom;
      1: return 32'($urandom_range(4194304));
      default: return $urandom_range(1) ? 32'hffffffff : 32'h0;
    endcase
  endfunction

  initial begin
    int k;
    for (int i = 0; i < 8; i++) begin
      body_x[i] = 0; body_y[i] = 0; body_z[i] = 0;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero count returns a zero vector
    send(isfe_pkg::opcode_eval, 3'd0, 24'sh7fffff, 24'sh800000, 24'sd1, 32'hffffffff);
    drain();
    set_active(4'd15);
    send(isfe_pkg::opcode_eval, 3'd5, 24'sd100, 24'sd0, 24'sd0, 32'd0);
    send(isfe_pkg::opcode_load, 3'd0, 24'sd0, 24'sd0, 24'sd0, 32'hffffffff);
    send(isfe_pkg::opcode_load, 3'd1, 24'sd0, 24'sd0, 24'sd0, 32'hffffffff);
    send(isfe_pkg::opcode_load, 3'd2, 24'sh7fffff, 24'sh800000, 24'sh7fffff, 32'h00400000);
    send(isfe_pkg::opcode_load, 3'd7, 24'sh800000, 24'sh7fffff, 24'sh800000, 32'h0);
    // point on top of a body, just inside and just outside the skip radius
    send(isfe_pkg::opcode_eval, 3'd0, 24'sd0, 24'sd0, 24'sd0, 32'd0);
    send(isfe_pkg::opcode_eval, 3'd0, 24'sd6, 24'sd0, 24'sd0, 32'd0);
    // two clipped terms in the same direction overflow the partial sum
    send(isfe_pkg::opcode_eval, 3'd0, 24'sd7, 24'sd0, 24'sd0, 32'd0);
    send(isfe_pkg::opcode_eval, 3'd0, -24'sd7, 24'sd3, -24'sd1, 32'd0);
    send(isfe_pkg::opcode_eval, 3'd0, 24'sh800000, 24'sh7fffff, 24'sh800000, 32'd0);
    send(isfe_pkg::opcode_eval, 3'd0, 24'sh7fffff, 24'sh7fffff, 24'sh7fffff, 32'd0);
    send(isfe_pkg::opcode_load, 3'd1, -24'sd65536, 24'sd65536, 24'sd0, 32'h00000001);
    send(isfe_pkg::opcode_eval, 3'd0, 24'sd65536, -24'sd65536, 24'sd12345, 32'd0);
    drain();
    set_active(4'd8);
    send(isfe_pkg::opcode_eval, 3'd0, 24'sd1000, -24'sd2000, 24'sd3000, 32'd0);
    send(isfe_pkg::opcode_eval, 3'd0, 24'sd0, 24'sd0, 24'sd0, 32'd0);

    for (int ph = 0; ph < 12; ph++) begin
      drain();
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 52; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 52; end
        default: begin send_idle = 38; recv_stall = 38; end
      endcase
      set_active(counts[ph]);
      for (int i = 0; i < 95; i++) begin
        if (i == 50 && ph == 5) drain();
        if ($urandom_range(1) == 0) begin
          send(isfe_pkg::opcode_load, 3'($urandom), pick_coord(), pick_coord(), pick_coord(),
               pick_mass());
        end else if ($urandom_range(2) == 0) begin
          send(isfe_pkg::opcode_eval, 3'($urandom), pick_coord(), pick_coord(), pick_coord(),
               $urandom);
        end else begin
          // a point near a body, often close enough to clip or skip
          k = $urandom_range(7);
          send(isfe_pkg::opcode_eval, 3'($urandom),
               body_x[k] + 24'($urandom_range(31)) - 24'sd16,
               body_y[k] + 24'($urandom_range(511)) - 24'sd256,
               body_z[k] + 24'($urandom_range(7)) - 24'sd4, $urandom);
        end
      end
    end
    drain();

    $display("sent %0d loads and %0d evaluations over 12 body counts and 4 idle mixes",
             loads_sent, evals_sent);
    $display("checked %0d field results, %0d errors", fields_seen, errors);
    if (errors == 0) begin
      $display("inverse_square_field_eval: match");
    end else begin
      $display("inverse_square_field_eval: mismatch");
    end
    $finish;
  end

  initial begin
    #200000000;
    $display("timeout with %0d field results outstanding", fields_waiting);
    $display("inverse_square_field_eval: mismatch");
    $finish;
  end
endmodule
